// File: rtl/xxh32_pkg.sv
// Shared types and constants for the streaming xxHash32 core.
// Holds the five hash primes and the operation word sent to the round unit.
// No dependencies; imported by xxh32_round_unit, xxhash32_stream_core and the testbench.
package xxh32_pkg;

  localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
  localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
  localparam logic [31:0] PRIME5 = 32'h1656_67B1;

  typedef enum logic [1:0] {
    PRE_PASS,
    PRE_ROT_SUM,
    PRE_SUM_ROT,
    PRE_XOR_SHR
  } pre_sel_t;

  typedef enum logic [2:0] {
    KM_ONE,
    KM_P1,
    KM_P2,
    KM_P3,
    KM_P4,
    KM_P5
  } kmul_sel_t;

  typedef struct packed {
    logic      issue;
    pre_sel_t  pre;
    logic [4:0] rot;
    kmul_sel_t kmul;
  } xxh32_op_t;

endpackage

// File: rtl/xxhash32_stream_core.sv
// Streaming xxHash32 core: sequencer, lane and message state, result register.
// Depends on xxh32_pkg and instantiates xxh32_round_unit.
//
// Usage: a message enters as little-endian 32-bit words on the in_ channel
// (in_valid/in_stall); in_byte_count gives the valid bytes of the word and
// in_last_word marks the end of the message. A word with fewer than four
// bytes also ends the message. The hash leaves on the out_ channel
// (out_valid/out_stall), one word per message. cfg_wr_en/cfg_wr_data load
// the seed; write it only while the core is idle, as the core does not enforce it.
// All work is done by one shared multiply unit, and a word is taken only while
// the core is idle. A full word that does not complete a stripe leaves it idle;
// the word that completes a 16-byte stripe needs two unit operations per lane,
// four lanes. The last word then needs two merge operations (four once a stripe
// was seen), two per pending word (0..3), two per tail byte (0..3) and three
// avalanche operations, then the result is loaded once the output register is
// free. The next word can be taken in the cycle after the result is loaded.
// After reset the seed is zero and no message is in progress. A stalled
// result is held in the output register; the core takes further words
// meanwhile and only waits once its next hash is ready.
module xxhash32_stream_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);
  import xxh32_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LANE_MUL,
    S_LANE_RND,
    S_LANE_END,
    S_MERGE,
    S_WORD_MUL,
    S_WORD_RND,
    S_BYTE_MUL,
    S_BYTE_RND,
    S_AVAL,
    S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [31:0] lane_r [4];
  logic [31:0] lane_nxt [4];
  logic [31:0] pend_r [4];
  logic [31:0] pend_nxt [4];
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic        stripe_r, stripe_nxt;
  logic [31:0] tail_word_r, tail_word_nxt;
  logic [1:0]  tail_n_r, tail_n_nxt;
  logic        last_r, last_nxt;
  logic [31:0] h_r, h_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  xxh32_op_t   op;
  logic [31:0] opnd_a;
  logic [31:0] opnd_b;
  logic [31:0] res;
  logic [2:0]  cnt_c;
  logic        full_c;
  logic        last_c;
  logic        in_acc;

  function automatic logic [31:0] lane_seed(input logic [1:0] i, input logic [31:0] s);
    logic [31:0] v;
    case (i)
      2'd0:    v = s + PRIME1 + PRIME2;
      2'd1:    v = s + PRIME2;
      2'd2:    v = s;
      default: v = s - PRIME1;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] merge_rot(input logic [1:0] i);
    logic [4:0] r;
    case (i)
      2'd0:    r = 5'd1;
      2'd1:    r = 5'd7;
      2'd2:    r = 5'd12;
      default: r = 5'd18;
    endcase
    return r;
  endfunction

  xxh32_round_unit u_round (
    .clk    (clk),
    .op     (op),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .result (res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign cnt_c    = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
  assign full_c   = (cnt_c == 3'd4);
  assign last_c   = in_last_word || !full_c;

  always_comb begin
    op        = '{issue: 1'b0, pre: PRE_PASS, rot: 5'd0, kmul: KM_ONE};
    opnd_a    = res;
    opnd_b    = res;

    state_nxt     = state_r;
    idx_nxt       = idx_r;
    seed_nxt      = seed_r;
    lane_nxt      = lane_r;
    pend_nxt      = pend_r;
    pcnt_nxt      = pcnt_r;
    blen_nxt      = blen_r;
    stripe_nxt    = stripe_r;
    tail_word_nxt = tail_word_r;
    tail_n_nxt    = tail_n_r;
    last_nxt      = last_r;
    h_nxt         = h_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_wr_en) begin
      seed_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          blen_nxt      = blen_r + {29'd0, cnt_c};
          tail_word_nxt = in_data_word;
          tail_n_nxt    = full_c ? 2'd0 : cnt_c[1:0];
          last_nxt      = last_c;
          idx_nxt       = 2'd0;
          if (full_c) begin
            pend_nxt[pcnt_r] = in_data_word;
            if (pcnt_r == 2'd3) begin
              pcnt_nxt  = 2'd0;
              state_nxt = S_LANE_MUL;
            end else begin
              pcnt_nxt  = pcnt_r + 2'd1;
              state_nxt = last_c ? S_MERGE : S_IDLE;
            end
          end else begin
            state_nxt = S_MERGE;
          end
        end
      end

      S_LANE_MUL: begin
        if (idx_r != 2'd0) begin
          lane_nxt[idx_r - 2'd1] = res;
        end
        op        = '{issue: 1'b1, pre: PRE_PASS, rot: 5'd0, kmul: KM_P2};
        opnd_a    = pend_r[idx_r];
        state_nxt = S_LANE_RND;
      end

      S_LANE_RND: begin
        op     = '{issue: 1'b1, pre: PRE_ROT_SUM, rot: 5'd13, kmul: KM_P1};
        opnd_a = stripe_r ? lane_r[idx_r] : lane_seed(idx_r, seed_r);
        opnd_b = res;
        if (idx_r == 2'd3) begin
          state_nxt = S_LANE_END;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_LANE_MUL;
        end
      end

      S_LANE_END: begin
        lane_nxt[3] = res;
        stripe_nxt  = 1'b1;
        idx_nxt     = 2'd0;
        state_nxt   = last_r ? S_MERGE : S_IDLE;
      end

      S_MERGE: begin
        op.issue = 1'b1;
        op.pre   = PRE_SUM_ROT;
        op.kmul  = KM_ONE;
        if (stripe_r) begin
          op.rot = merge_rot(idx_r);
          opnd_a = (idx_r == 2'd0) ? blen_r : res;
          opnd_b = lane_r[idx_r];
        end else begin
          op.rot = 5'd0;
          opnd_a = (idx_r == 2'd0) ? seed_r : res;
          opnd_b = (idx_r == 2'd0) ? PRIME5 : blen_r;
        end
        if ((stripe_r && idx_r == 2'd3) || (!stripe_r && idx_r == 2'd1)) begin
          idx_nxt = 2'd0;
          if (pcnt_r != 2'd0) begin
            state_nxt = S_WORD_MUL;
          end else if (tail_n_r != 2'd0) begin
            state_nxt = S_BYTE_MUL;
          end else begin
            state_nxt = S_AVAL;
          end
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      S_WORD_MUL: begin
        h_nxt     = res;
        op        = '{issue: 1'b1, pre: PRE_PASS, rot: 5'd0, kmul: KM_P3};
        opnd_a    = pend_r[idx_r];
        state_nxt = S_WORD_RND;
      end

      S_WORD_RND: begin
        op     = '{issue: 1'b1, pre: PRE_ROT_SUM, rot: 5'd17, kmul: KM_P4};
        opnd_a = h_r;
        opnd_b = res;
        if (idx_r == pcnt_r - 2'd1) begin
          idx_nxt   = 2'd0;
          state_nxt = (tail_n_r != 2'd0) ? S_BYTE_MUL : S_AVAL;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_WORD_MUL;
        end
      end

      S_BYTE_MUL: begin
        h_nxt     = res;
        op        = '{issue: 1'b1, pre: PRE_PASS, rot: 5'd0, kmul: KM_P5};
        opnd_a    = {24'd0, tail_word_r[{idx_r, 3'b000} +: 8]};
        state_nxt = S_BYTE_RND;
      end

      S_BYTE_RND: begin
        op     = '{issue: 1'b1, pre: PRE_ROT_SUM, rot: 5'd11, kmul: KM_P1};
        opnd_a = h_r;
        opnd_b = res;
        if (idx_r == tail_n_r - 2'd1) begin
          idx_nxt   = 2'd0;
          state_nxt = S_AVAL;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_BYTE_MUL;
        end
      end

      S_AVAL: begin
        op.issue = 1'b1;
        op.pre   = PRE_XOR_SHR;
        opnd_a   = res;
        case (idx_r)
          2'd0: begin
            op.rot  = 5'd15;
            op.kmul = KM_P2;
          end
          2'd1: begin
            op.rot  = 5'd13;
            op.kmul = KM_P3;
          end
          default: begin
            op.rot  = 5'd16;
            op.kmul = KM_ONE;
          end
        endcase
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = res;
          pcnt_nxt      = 2'd0;
          blen_nxt      = 32'd0;
          stripe_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      seed_r      <= 32'd0;
      pcnt_r      <= 2'd0;
      blen_r      <= 32'd0;
      stripe_r    <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      seed_r      <= seed_nxt;
      lane_r      <= lane_nxt;
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      blen_r      <= blen_nxt;
      stripe_r    <= stripe_nxt;
      tail_word_r <= tail_word_nxt;
      tail_n_r    <= tail_n_nxt;
      last_r      <= last_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
      out_hash_r  <= out_hash_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// File: rtl/xxh32_round_unit.sv
// Shared arithmetic unit of the xxHash32 core: add, rotate or xor-shift, then
// multiply by a selected prime or by one, with the product registered.
// Depends on xxh32_pkg for the primes and the operation word.
module xxh32_round_unit (
  input  logic                  clk,
  input  xxh32_pkg::xxh32_op_t  op,
  input  logic [31:0]           opnd_a,
  input  logic [31:0]           opnd_b,
  output logic [31:0]           result
);
  import xxh32_pkg::*;

  logic [31:0] pre_val;
  logic [31:0] kval;
  logic [31:0] prod;
  logic [31:0] result_r;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [5:0] rs;
    rs = 6'd32 - {1'b0, s};
    return (v << s) | (v >> rs);
  endfunction

  always_comb begin
    case (op.pre)
      PRE_PASS:    pre_val = opnd_a;
      PRE_ROT_SUM: pre_val = rotl32(opnd_a + opnd_b, op.rot);
      PRE_SUM_ROT: pre_val = opnd_a + rotl32(opnd_b, op.rot);
      PRE_XOR_SHR: pre_val = opnd_a ^ (opnd_a >> op.rot);
      default:     pre_val = opnd_a;
    endcase
  end

  always_comb begin
    case (op.kmul)
      KM_ONE:  kval = 32'd1;
      KM_P1:   kval = PRIME1;
      KM_P2:   kval = PRIME2;
      KM_P3:   kval = PRIME3;
      KM_P4:   kval = PRIME4;
      KM_P5:   kval = PRIME5;
      default: kval = 32'd1;
    endcase
  end

  assign prod = pre_val * kval;

  always_ff @(posedge clk) begin
    if (op.issue) begin
      result_r <= prod;
    end
  end

  assign result = result_r;

endmodule

// File: tb/sv/xxhash32_stream_core_test.sv
// Self-checking testbench for xxhash32_stream_core: directed and random messages under
// several seeds, with random idling on both channels and a long hold-off on the result side.
// Depends on the xxh32_pkg package and the xxhash32_stream_core RTL.
`timescale 1ns / 100ps

module xxhash32_stream_core_test;
  import xxh32_pkg::*;

  class xxh_hash_tracker;
    logic [31:0] seed;
    logic [31:0] lane [4];
    logic [31:0] held_words [4];
    int unsigned held_n;
    logic [31:0] msg_len;
    bit stripe_seen;
    logic [31:0] pending_hashes [$];
    int unsigned errors;
    int unsigned words_taken;
    int unsigned hashes_checked;

    function new();
      seed = '0;
      errors = 0;
      words_taken = 0;
      hashes_checked = 0;
      start_message();
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void seed_lanes();
      lane[0] = seed + PRIME1 + PRIME2;
      lane[1] = seed + PRIME2;
      lane[2] = seed;
      lane[3] = seed - PRIME1;
    endfunction

    function void start_message();
      seed_lanes();
      held_n = 0;
      msg_len = '0;
      stripe_seen = 1'b0;
    endfunction

    // A new seed restarts the lanes only while no stripe has been absorbed.
    function void load_seed(logic [31:0] value);
      seed = value;
      if (!stripe_seen) seed_lanes();
    endfunction

    function logic [31:0] close_message(logic [31:0] tail, int unsigned n_bytes);
      logic [31:0] h;
      logic [31:0] b;
      if (stripe_seen)
        h = rotl(lane[0], 1) + rotl(lane[1], 7) + rotl(lane[2], 12) + rotl(lane[3], 18);
      else
        h = seed + PRIME5;
      h = h + msg_len;
      for (int unsigned i = 0; i < held_n; i++)
        h = rotl(h + held_words[i] * PRIME3, 17) * PRIME4;
      for (int unsigned i = 0; i < n_bytes; i++) begin
        b = {24'h0, tail[8*i +: 8]};
        h = rotl(h + b * PRIME5, 11) * PRIME1;
      end
      h = h ^ (h >> 15);
      h = h * PRIME2;
      h = h ^ (h >> 13);
      h = h * PRIME3;
      h = h ^ (h >> 16);
      return h;
    endfunction

    task note_word(logic [31:0] data, logic [2:0] count, logic last);
      int unsigned n;
      bit ends;
      n = (count > 3'd4) ? 4 : count;
      ends = last || (n < 4);
      words_taken++;
      msg_len = msg_len + n;
      if (n == 4) begin
        held_words[held_n] = data;
        held_n++;
        if (held_n == 4) begin
          for (int unsigned i = 0; i < 4; i++)
            lane[i] = rotl(lane[i] + held_words[i] * PRIME2, 13) * PRIME1;
          stripe_seen = 1'b1;
          held_n = 0;
        end
      end
      if (ends) begin
        pending_hashes = {pending_hashes, close_message(data, (n < 4) ? n : 0)};
        start_message();
      end
    endtask

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_hash(logic [31:0] hash);
      logic [31:0] want;
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %08h with no message outstanding", hash));
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked++;
        if (hash !== want)
          report_mismatch($sformatf("hash %08h, expected %08h", hash, want));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;

  xxh_hash_tracker tracker = new();
  bit steady = 1'b0;
  bit pressure_on = 1'b0;
  bit pressure_done = 1'b0;
  int unsigned seeds_loaded = 0;

  xxhash32_stream_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_word(in_data_word),
    .in_byte_count(in_byte_count),
    .in_last_word(in_last_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hash_value(out_hash_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_hash(out_hash_value);
      if (in_valid && !in_stall) tracker.note_word(in_data_word, in_byte_count, in_last_word);
    end
  end

  // The result side stalls at random, once holds off long enough to back up the input.
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_on && !pressure_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 21);
      end
    end
  end

  task automatic send_word(logic [31:0] data, logic [2:0] count, logic last);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= data;
    in_byte_count <= count;
    in_last_word <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_message();
    int unsigned n_words;
    logic [2:0] count;
    logic last;
    n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
    for (int unsigned i = 0; i + 1 < n_words; i++) begin
      if ($urandom_range(0, 29) == 0)
        count = 3'($urandom_range(0, 3));
      else
        count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
      send_word($urandom, count, 1'b0);
    end
    count = 3'($urandom_range(0, 7));
    last = (count < 3'd4) ? ($urandom_range(0, 4) != 0) : 1'b1;
    send_word($urandom, count, last);
  endtask

  // The seed is only changed once every hash is out and the core has settled.
  task automatic load_seed_when_idle(logic [31:0] value);
    in_valid <= 1'b0;
    while (tracker.pending_hashes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.load_seed(value);
    seeds_loaded++;
  endtask

  initial begin
    logic [31:0] seed_list [6];
    logic [31:0] seed_val;
    int unsigned target;
    seed_list = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0000_0001, 32'h0, 32'h8000_0000};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hFFFF_FF61, 3'd1, 1'b0);
    send_word(32'hA5A5_5A5A, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b0);
    send_word(32'h1234_5678, 3'd6, 1'b0);
    send_word(32'hDEAD_BEEF, 3'd4, 1'b1);
    repeat (4) send_word($urandom, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'hCAFE_F00D, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    repeat (7) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);

    for (int p = 0; p < 6; p++) begin
      seed_val = (p == 2 || p == 4) ? $urandom : seed_list[p];
      load_seed_when_idle(seed_val);
      steady = (p == 2);
      if (p == 3) pressure_on = 1'b1;
      target = tracker.words_taken + 330;
      while (tracker.words_taken < target) send_random_message();
    end

    in_valid <= 1'b0;
    while (tracker.pending_hashes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d words and %0d hashes across reset seed and %0d seed writes.",
             tracker.words_taken, tracker.hashes_checked, seeds_loaded);
    $display("Mismatches found: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("xxhash32_stream_core_test: done, clean");
    end else begin
      $display("xxhash32_stream_core_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Run timed out.");
    $display("xxhash32_stream_core_test: done, errors");
    $finish;
  end

endmodule
